### hw/rtl/hgtm_pkg.sv
package hgtm_pkg;

	localparam int NUM_FINGERS = 5;
	localparam int READING_W = 12;
	localparam int ANGLE_W = 13;
	localparam int ID_W = 4;
	localparam int ROM_SIZE = 9;
	localparam int TEMPLATE_COUNT_DEF = 9;
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [READING_W-1:0] MID_RESET = 12'd2048;
	localparam logic [ID_W-1:0] NONE_ANNOUNCED = 4'd15;

	localparam logic [REG_IDX_W-1:0] REG_MID_THUMB = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_MID_INDEX = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MID_MIDDLE = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_MID_RING = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MID_PINKY = 3'd4;

	typedef logic [READING_W-1:0] reading_t;
	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef reading_t [NUM_FINGERS-1:0] finger_vec_t;

	typedef enum logic [ID_W-1:0] {
		GEST_OK = 4'd0,
		GEST_FIST = 4'd1,
		GEST_IDLE = 4'd2,
		GEST_ONE = 4'd3,
		GEST_TWO = 4'd4,
		GEST_THREE = 4'd5,
		GEST_ZERO = 4'd6,
		GEST_VICTORY = 4'd7,
		GEST_HI = 4'd8
	} gesture_e;

	typedef enum logic [1:0] {F_STRAIGHT, F_BENT, F_ANY} finger_want_e;
	typedef enum logic [1:0] {T_CLOSE, T_APART, T_EACH} touch_want_e;
	typedef enum logic [1:0] {ANG_A, ANG_B, ANG_C} ang_kind_e;

	typedef finger_want_e [NUM_FINGERS-1:0] finger_set_t;

	typedef struct packed {
		finger_set_t finger;
		touch_want_e [1:0] touch;
		ang_kind_e ang;
	} tmpl_t;

	typedef struct packed {
		angle_t [1:0] roll_lo;
		angle_t [1:0] roll_hi;
		angle_t [1:0] pitch_lo;
		angle_t [1:0] pitch_hi;
	} ang_set_t;

	typedef struct packed {
		logic hit;
		logic [ID_W-1:0] id;
	} match_res_t;

	// limits in 1/16 degree
	function automatic ang_set_t ang_set(input ang_kind_e k);
		ang_set_t s;
		case (k)
			ANG_A: begin
				s.roll_lo = {-13'sd1440, -13'sd1440};
				s.roll_hi = {-13'sd400, -13'sd400};
				s.pitch_lo = {-13'sd1440, -13'sd1440};
				s.pitch_hi = {13'sd960, 13'sd960};
			end
			ANG_B: begin
				s.roll_lo = {-13'sd2560, 13'sd2080};
				s.roll_hi = {13'sd0, 13'sd3040};
				s.pitch_lo = {-13'sd3040, 13'sd2400};
				s.pitch_hi = {-13'sd2400, 13'sd3040};
			end
			default: begin
				s.roll_lo = {-13'sd2400, -13'sd2400};
				s.roll_hi = {13'sd2400, 13'sd2400};
				s.pitch_lo = {-13'sd1920, -13'sd1920};
				s.pitch_hi = {-13'sd1440, -13'sd1440};
			end
		endcase
		return s;
	endfunction

	function automatic finger_set_t fingers(input finger_want_e th, ix, md, rg, pk);
		finger_set_t f;
		f[0] = th;
		f[1] = ix;
		f[2] = md;
		f[3] = rg;
		f[4] = pk;
		return f;
	endfunction

	function automatic tmpl_t tmpl_rom(input logic [ID_W-1:0] idx);
		tmpl_t t;
		t.touch = {T_EACH, T_EACH};
		t.ang = ANG_B;
		case (idx)
			GEST_OK: begin
				t.finger = fingers(F_STRAIGHT, F_BENT, F_BENT, F_BENT, F_BENT);
				t.ang = ANG_A;
			end
			GEST_FIST: t.finger = fingers(F_BENT, F_BENT, F_BENT, F_BENT, F_BENT);
			GEST_IDLE: t.finger = fingers(F_STRAIGHT, F_STRAIGHT, F_STRAIGHT, F_STRAIGHT,
				F_STRAIGHT);
			GEST_ONE: t.finger = fingers(F_STRAIGHT, F_BENT, F_BENT, F_BENT, F_BENT);
			GEST_TWO: t.finger = fingers(F_STRAIGHT, F_STRAIGHT, F_BENT, F_BENT, F_BENT);
			GEST_THREE: t.finger = fingers(F_STRAIGHT, F_STRAIGHT, F_STRAIGHT, F_BENT, F_BENT);
			GEST_ZERO: begin
				t.finger = fingers(F_BENT, F_BENT, F_STRAIGHT, F_STRAIGHT, F_STRAIGHT);
				t.touch = {T_APART, T_CLOSE};
				t.ang = ANG_A;
			end
			GEST_VICTORY: begin
				t.finger = fingers(F_BENT, F_STRAIGHT, F_STRAIGHT, F_BENT, F_BENT);
				t.ang = ANG_C;
			end
			GEST_HI: begin
				t.finger = fingers(F_STRAIGHT, F_STRAIGHT, F_STRAIGHT, F_STRAIGHT, F_STRAIGHT);
				t.ang = ANG_C;
			end
			default: begin
				t.finger = fingers(F_ANY, F_ANY, F_ANY, F_ANY, F_ANY);
				t.ang = ANG_C;
			end
		endcase
		return t;
	endfunction

endpackage

### hw/rtl/hgtm_apb_regs.sv
module hgtm_apb_regs
	import hgtm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [APB_ADDR_W-1:0] paddr,
	input logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic pready,
	output finger_vec_t mid
);

	finger_vec_t mid_q;
	logic [REG_IDX_W-1:0] idx;
	logic wr;

	assign idx = paddr[APB_ADDR_W-1:2];
	assign wr = psel & penable & pwrite;
	assign pready = 1'b1;
	assign mid = mid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_FINGERS; k++) mid_q[k] <= MID_RESET;
		end else if (wr) begin
			for (int k = 0; k < NUM_FINGERS; k++) begin
				if (idx == REG_IDX_W'(k)) mid_q[k] <= pwdata[READING_W-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_MID_THUMB: prdata[READING_W-1:0] = mid_q[0];
			REG_MID_INDEX: prdata[READING_W-1:0] = mid_q[1];
			REG_MID_MIDDLE: prdata[READING_W-1:0] = mid_q[2];
			REG_MID_RING: prdata[READING_W-1:0] = mid_q[3];
			REG_MID_PINKY: prdata[READING_W-1:0] = mid_q[4];
			default: prdata = '0;
		endcase
	end

endmodule

### hw/rtl/hgtm_match.sv
module hgtm_match
	import hgtm_pkg::*;
#(
	parameter int TEMPLATE_COUNT = TEMPLATE_COUNT_DEF
) (
	input finger_vec_t flex,
	input finger_vec_t mid,
	input logic touch_index,
	input logic touch_middle,
	input angle_t roll_angle,
	input angle_t pitch_angle,
	output match_res_t res
);

	localparam int LANES = (TEMPLATE_COUNT < ROM_SIZE) ? TEMPLATE_COUNT : ROM_SIZE;

	logic [LANES-1:0] hit;

	function automatic logic finger_ok(input reading_t r, input finger_want_e w,
		input reading_t m);
		logic ok;
		case (w)
			F_STRAIGHT: ok = (r >= m);
			F_BENT: ok = (r < m);
			default: ok = 1'b1;
		endcase
		return ok;
	endfunction

	function automatic logic touch_ok(input logic b, input touch_want_e w);
		logic ok;
		case (w)
			T_CLOSE: ok = b;
			T_APART: ok = ~b;
			default: ok = 1'b1;
		endcase
		return ok;
	endfunction

	function automatic logic in_span(input angle_t v, input angle_t lo, input angle_t hi);
		return (v >= lo) && (v <= hi);
	endfunction

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		tmpl_t t;
		ang_set_t a;
		logic [NUM_FINGERS-1:0] f_ok;
		logic roll_ok;
		logic pitch_ok;

		assign t = tmpl_rom(ID_W'(g));
		assign a = ang_set(t.ang);

		for (genvar f = 0; f < NUM_FINGERS; f++) begin : g_finger
			assign f_ok[f] = finger_ok(flex[f], t.finger[f], mid[f]);
		end

		assign roll_ok = in_span(roll_angle, a.roll_lo[0], a.roll_hi[0])
			|| in_span(roll_angle, a.roll_lo[1], a.roll_hi[1]);
		assign pitch_ok = in_span(pitch_angle, a.pitch_lo[0], a.pitch_hi[0])
			|| in_span(pitch_angle, a.pitch_lo[1], a.pitch_hi[1]);

		assign hit[g] = (&f_ok) && touch_ok(touch_index, t.touch[0])
			&& touch_ok(touch_middle, t.touch[1]) && roll_ok && pitch_ok;
	end

	// lowest template wins
	always_comb begin
		res.hit = 1'b0;
		res.id = '0;
		for (int k = LANES - 1; k >= 0; k--) begin
			if (hit[k]) begin
				res.hit = 1'b1;
				res.id = ID_W'(k);
			end
		end
	end

endmodule

### hw/rtl/hand_gesture_template_matcher.sv
// channel  | direction | handshake                   | payload
// sample   | in        | sample_valid / sample_ready | flex_*, touch_*, roll_angle, pitch_angle
// result   | out       | result_valid / result_ready | matched, gesture_id, announce
// config   | in        | APB psel/penable/pwrite     | mid_* at paddr 4*i
//
// One sample per cycle while result_ready does not stall; an accepted sample passes
// through the input register, then compare/priority logic into the result register.
// Reset clears valids and the last announced gesture (none) and loads 2048
// into the mid values.
// A stall on result_ready holds both stages; sample_ready drops only when
// the input stage is full and cannot advance.
module hand_gesture_template_matcher
	import hgtm_pkg::*;
#(
	parameter int TEMPLATE_COUNT = TEMPLATE_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,

	input logic sample_valid,
	output logic sample_ready,
	input logic [READING_W-1:0] flex_thumb,
	input logic [READING_W-1:0] flex_index,
	input logic [READING_W-1:0] flex_middle,
	input logic [READING_W-1:0] flex_ring,
	input logic [READING_W-1:0] flex_pinky,
	input logic touch_index,
	input logic touch_middle,
	input logic signed [ANGLE_W-1:0] roll_angle,
	input logic signed [ANGLE_W-1:0] pitch_angle,

	output logic result_valid,
	input logic result_ready,
	output logic matched,
	output logic [ID_W-1:0] gesture_id,
	output logic announce,

	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [APB_ADDR_W-1:0] paddr,
	input logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic pready
);

	finger_vec_t mid;
	finger_vec_t flex_s1;
	logic touch_index_s1;
	logic touch_middle_s1;
	angle_t roll_s1;
	angle_t pitch_s1;
	logic valid_s1;

	logic valid_s2;
	logic matched_s2;
	logic [ID_W-1:0] gesture_id_s2;
	logic announce_s2;
	logic [ID_W-1:0] last_q;

	match_res_t res;
	logic advance;
	logic new_gesture;

	hgtm_apb_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.mid(mid)
	);

	hgtm_match #(
		.TEMPLATE_COUNT(TEMPLATE_COUNT)
	) u_match (
		.flex(flex_s1),
		.mid(mid),
		.touch_index(touch_index_s1),
		.touch_middle(touch_middle_s1),
		.roll_angle(roll_s1),
		.pitch_angle(pitch_s1),
		.res(res)
	);

	assign advance = ~valid_s2 | result_ready;
	assign sample_ready = ~valid_s1 | advance;
	assign new_gesture = res.hit && (res.id != last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			flex_s1 <= {flex_pinky, flex_ring, flex_middle, flex_index, flex_thumb};
			touch_index_s1 <= touch_index;
			touch_middle_s1 <= touch_middle;
			roll_s1 <= roll_angle;
			pitch_s1 <= pitch_angle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			last_q <= NONE_ANNOUNCED;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1 && new_gesture) last_q <= res.id;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			matched_s2 <= res.hit;
			gesture_id_s2 <= res.id;
			announce_s2 <= new_gesture;
		end
	end

	assign result_valid = valid_s2;
	assign matched = matched_s2;
	assign gesture_id = gesture_id_s2;
	assign announce = announce_s2;

endmodule
